/* rtl/core/shp_pkg.sv */
// ----------------------------------------------------------------------------
// shp_pkg
// Shared types and constants for the 3x3 sharpen filter with mirrored borders.
// ----------------------------------------------------------------------------
package shp_pkg;

  localparam int PIX_W = 8;
  localparam int OUT_W = 10;
  localparam int CFG_W = 11;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // window indexed [row][col], row 0 is two rows up, col 0 is two columns back
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  // up to four results of one input, slot index is {row step, column step}
  typedef struct packed {
    logic [3:0][PIX_W-1:0] pix;
    logic [OUT_W-1:0]      row0;
    logic [OUT_W-1:0]      col0;
    logic                  two_rows;
    logic                  two_cols;
  } slot_set_t;

endpackage

/* rtl/core/sharpen_3x3_reflect_clamp_unit.sv */
// ----------------------------------------------------------------------------
// sharpen_3x3_reflect_clamp_unit
// 3x3 sharpen filter over a streamed grey frame with mirrored borders.
//
// Pixels enter in row-major order on in_valid/in_ready/pixel_in; results
// leave on out_valid/out_ready with pixel_out, out_row, out_col, run_last
// and frame_last. An accepted pixel is held in the input stage while the
// line store pair is read, then its results (none, one, two or four)
// are loaded into the result register, which shows the first of them.
// The next set may load as the last result of the current one is taken.
// Interior pixels have one result each. A pixel at a row end has two,
// and in the last row two or four; the single result port drains the
// result register one transfer a cycle while out_ready is high.
// cfg_write with cfg_index/cfg_data sets image_width or image_height,
// clamped to 2..MAX, and restarts the frame at (0,0); write only while idle.
// Reset sets both sizes to 4 (or MAX if smaller) and the position to (0,0); the line stores
// need no clearing. When the receiver stalls, the result register holds and
// one more pixel may wait in the input stage before in_ready drops.
// ----------------------------------------------------------------------------
module sharpen_3x3_reflect_clamp_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [shp_pkg::IDX_W-1:0] cfg_index,
  input  logic [shp_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [shp_pkg::PIX_W-1:0] pixel_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [shp_pkg::PIX_W-1:0] pixel_out,
  output logic [shp_pkg::OUT_W-1:0] out_row,
  output logic [shp_pkg::OUT_W-1:0] out_col,
  output logic                      run_last,
  output logic                      frame_last
);

  import shp_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int RST_W = (MAX_WIDTH < 4) ? MAX_WIDTH : 4;
  localparam int RST_H = (MAX_HEIGHT < 4) ? MAX_HEIGHT : 4;

  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;
  logic [CW-1:0] col;
  logic [RW-1:0] row;

  logic             valid_a;
  logic [PIX_W-1:0] p_a;
  logic [CW-1:0]    col_a;
  logic [RW-1:0]    row_a;
  win_t             win;
  win_t             win_next;

  logic [2*PIX_W-1:0] rd_data;
  logic               accept;
  logic               advance_a;
  logic               emit_any;
  logic               b_free;
  logic               load;
  logic               top_row;
  logic               left_col;
  logic [RW-1:0]      row_m1;
  logic [CW-1:0]      col_m1;
  logic [CFG_W-1:0]   cfg_m1;
  logic [CW-1:0]      w_clamped;
  logic [RW-1:0]      h_clamped;
  slot_set_t          set_d;

  // configuration, clamped to the usable range
  always_comb begin
    cfg_m1 = cfg_data - CFG_W'(1);
    if (cfg_data < CFG_W'(2)) begin
      w_clamped = CW'(1);
    end else if ({2'b00, cfg_data} > 13'(MAX_WIDTH)) begin
      w_clamped = CW'(MAX_WIDTH - 1);
    end else begin
      w_clamped = CW'(cfg_m1);
    end
    if (cfg_data < CFG_W'(2)) begin
      h_clamped = RW'(1);
    end else if ({2'b00, cfg_data} > 13'(MAX_HEIGHT)) begin
      h_clamped = RW'(MAX_HEIGHT - 1);
    end else begin
      h_clamped = RW'(cfg_m1);
    end
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wm1 <= CW'(RST_W - 1);
      hm1 <= RW'(RST_H - 1);
      col <= '0;
      row <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          wm1 <= w_clamped;
          col <= '0;
          row <= '0;
        end
        CFG_IMAGE_HEIGHT: begin
          hm1 <= h_clamped;
          col <= '0;
          row <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col == wm1) begin
        col <= '0;
        row <= (row == hm1) ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // line store pair: upper byte two rows up, lower byte one row up
  shp_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (advance_a),
    .waddr (col_a),
    .wdata ({rd_data[PIX_W-1:0], p_a}),
    .re    (accept),
    .raddr (col),
    .rdata (rd_data)
  );

  // input stage
  assign emit_any  = (row_a != '0) && (col_a != '0);
  assign advance_a = valid_a && (!emit_any || b_free);
  assign load      = valid_a && emit_any && b_free;
  assign in_ready  = !valid_a || advance_a;
  assign top_row   = (row_a == RW'(1));
  assign left_col  = (col_a == CW'(1));
  assign row_m1    = row_a - RW'(1);
  assign col_m1    = col_a - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (accept) begin
      valid_a <= 1'b1;
    end else if (advance_a) begin
      valid_a <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_a   <= pixel_in;
      col_a <= col;
      row_a <= row;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k][0] = win[k][1];
      win_next[k][1] = win[k][2];
    end
    win_next[0][2] = rd_data[2*PIX_W-1:PIX_W];
    win_next[1][2] = rd_data[PIX_W-1:0];
    win_next[2][2] = p_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (advance_a) begin
      win <= win_next;
    end
  end

  // four kernel slots, mirrored neighbours picked at the top row and left column and in the bottom and right slots
  for (genvar s = 0; s < 4; s++) begin : g_slot
    localparam int RS = s / 2;
    localparam int CS = s % 2;
    localparam int CR = 1 + RS;
    localparam int CC = 1 + CS;
    logic [PIX_W-1:0] up_px;
    logic [PIX_W-1:0] dn_px;
    logic [PIX_W-1:0] lf_px;
    logic [PIX_W-1:0] rt_px;

    if (RS == 1) begin : g_low
      assign up_px = win_next[1][CC];
      assign dn_px = win_next[1][CC];
    end else begin : g_high
      assign up_px = top_row ? win_next[2][CC] : win_next[0][CC];
      assign dn_px = win_next[2][CC];
    end

    if (CS == 1) begin : g_right
      assign lf_px = win_next[CR][1];
      assign rt_px = win_next[CR][1];
    end else begin : g_left
      assign lf_px = left_col ? win_next[CR][2] : win_next[CR][0];
      assign rt_px = win_next[CR][2];
    end

    shp_kernel u_kernel (
      .centre (win_next[CR][CC]),
      .up     (up_px),
      .dn     (dn_px),
      .lf     (lf_px),
      .rt     (rt_px),
      .pix    (set_d.pix[s])
    );
  end

  assign set_d.row0     = OUT_W'(row_m1);
  assign set_d.col0     = OUT_W'(col_m1);
  assign set_d.two_rows = (row_a == hm1);
  assign set_d.two_cols = (col_a == wm1);

  shp_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .set_in     (set_d),
    .free       (b_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .out_row    (out_row),
    .out_col    (out_col),
    .run_last   (run_last),
    .frame_last (frame_last)
  );

endmodule

/* rtl/core/shp_ram.sv */
// ----------------------------------------------------------------------------
// shp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module shp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/shp_kernel.sv */
// ----------------------------------------------------------------------------
// shp_kernel
// Five-point sharpen: 5*centre minus four neighbours, clamped to 0..255.
// ----------------------------------------------------------------------------
module shp_kernel (
  input  logic [shp_pkg::PIX_W-1:0] centre,
  input  logic [shp_pkg::PIX_W-1:0] up,
  input  logic [shp_pkg::PIX_W-1:0] dn,
  input  logic [shp_pkg::PIX_W-1:0] lf,
  input  logic [shp_pkg::PIX_W-1:0] rt,
  output logic [shp_pkg::PIX_W-1:0] pix
);

  import shp_pkg::*;

  logic signed [11:0] sum;

  always_comb begin
    sum = $signed({2'b00, centre, 2'b00}) + $signed({4'b0000, centre})
        - $signed({4'b0000, up}) - $signed({4'b0000, dn})
        - $signed({4'b0000, lf}) - $signed({4'b0000, rt});
    if (sum[11]) begin
      pix = '0;
    end else if (sum[10:8] != 3'b000) begin
      pix = '1;
    end else begin
      pix = sum[7:0];
    end
  end

endmodule

/* rtl/core/shp_emit.sv */
// ----------------------------------------------------------------------------
// shp_emit
// Result register: holds the results of one input and hands them out in
// row-major order, one per transfer.
// ----------------------------------------------------------------------------
module shp_emit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  shp_pkg::slot_set_t        set_in,
  output logic                      free,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [shp_pkg::PIX_W-1:0] pixel_out,
  output logic [shp_pkg::OUT_W-1:0] out_row,
  output logic [shp_pkg::OUT_W-1:0] out_col,
  output logic                      run_last,
  output logic                      frame_last
);

  import shp_pkg::*;

  slot_set_t  set_q;
  logic       valid_b;
  logic [1:0] k;
  logic [1:0] k_last;
  logic       take;
  logic       rs;
  logic       cs;

  always_comb begin
    if (set_q.two_rows && set_q.two_cols) begin
      k_last = 2'd3;
    end else if (set_q.two_rows || set_q.two_cols) begin
      k_last = 2'd1;
    end else begin
      k_last = 2'd0;
    end
    rs = set_q.two_cols ? k[1] : k[0];
    cs = set_q.two_cols ? k[0] : 1'b0;
  end

  assign out_valid  = valid_b;
  assign take       = valid_b && out_ready;
  assign run_last   = (k == k_last);
  assign free       = !valid_b || (take && run_last);
  assign pixel_out  = set_q.pix[{rs, cs}];
  assign out_row    = set_q.row0 + OUT_W'(rs);
  assign out_col    = set_q.col0 + OUT_W'(cs);
  // only the bottom-right slot of a four-result set can end the frame
  assign frame_last = set_q.two_rows && set_q.two_cols && run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
      k       <= '0;
    end else if (load && free) begin
      valid_b <= 1'b1;
      k       <= '0;
    end else if (take) begin
      if (run_last) begin
        valid_b <= 1'b0;
      end else begin
        k <= k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      set_q <= set_in;
    end
  end

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    valid_b |-> (k <= k_last))
    else $error("result slot index beyond set size");

  a_frame_run: assert property (@(posedge clk) disable iff (rst)
    (valid_b && frame_last) |-> run_last)
    else $error("frame end not on last result of its input");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (take && run_last && !load) |=> !out_valid)
    else $error("result register not emptied after last transfer");

endmodule
